>>> hdl/pket_pkg.sv
// Shared constants, types and action codes of the pending key event table.
// Used by the channel interfaces and by the top level; depends on nothing.
package pket_pkg;

  // table geometry
  localparam int CHANNEL_COUNT = 16;
  localparam int KEY_COUNT     = 128;

  // fixed field widths
  localparam int ACT_W  = 3;
  localparam int CHAN_W = 4;
  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int POS_W  = 8;

  // derived address widths
  localparam int CH_AW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int KEY_AW = $clog2(KEY_COUNT);
  localparam int VEL_AW = CH_AW + KEY_AW;
  localparam int VEL_DEPTH = 2 ** VEL_AW;

  // scan is split into groups of keys for the two-level priority search
  localparam int GRP_W   = 16;
  localparam int GRP_AW  = $clog2(GRP_W);
  localparam int NGRP    = (KEY_COUNT + GRP_W - 1) / GRP_W;
  localparam int NGRP_AW = (NGRP > 1) ? $clog2(NGRP) : 1;

  // action codes
  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_NOTE_ON  = 3'd0;
  localparam action_t ACT_NOTE_OFF = 3'd1;
  localparam action_t ACT_POP_ON   = 3'd2;
  localparam action_t ACT_POP_OFF  = 3'd3;
  localparam action_t ACT_READ     = 3'd4;
  localparam action_t ACT_CLEAR    = 3'd5;

  // one channel row of the flag memory
  typedef struct packed {
    logic [KEY_COUNT-1:0] written;
    logic [KEY_COUNT-1:0] pend_off;
    logic [KEY_COUNT-1:0] pend_on;
  } row_t;

endpackage

>>> hdl/pket_in_if.sv
// Event channel of the pending key event table: valid/ready plus the event fields.
// Depends on pket_pkg.
interface pket_in_if import pket_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAN_W-1:0] chan;
  logic [KEY_W-1:0]  key_number;
  logic [VEL_W-1:0]  new_velocity;

  modport source (output valid, action, chan, key_number, new_velocity, input ready);
  modport sink   (input valid, action, chan, key_number, new_velocity, output ready);
endinterface

>>> hdl/pket_out_if.sv
// Result channel of the pending key event table: valid/ready plus the result fields.
// Depends on pket_pkg.
interface pket_out_if import pket_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [KEY_W-1:0] found_key;
  logic [VEL_W-1:0] read_velocity;

  modport source (output valid, found, found_key, read_velocity, input ready);
  modport sink   (input valid, found, found_key, read_velocity, output ready);
endinterface

>>> hdl/pket_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone, no package dependency.
module pket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/pending_key_event_table.sv
// Top level of the pending key event table.
// Depends on pket_pkg, pket_in_if, pket_out_if and pket_ram.
//
// Usage:
//   req carries key events (note on/off, pop on/off, read velocity, clear
//   pending) with channel, key and velocity. rsp returns one result for each
//   pop and each read, in order; other actions return nothing.
//   Velocities live in a 2048 x 7 RAM, and each channel has one row in a
//   16-entry flag RAM with pending-on, pending-off and written bits per key.
//   One event is processed at a time, paced by the read-modify-write of the
//   flag row and the two-level priority search over its keys. Note on/off
//   and clear update the row and return to idle; read velocity loads the
//   result register; pop on/off runs row read, mask, group search, pick
//   and result load, in that order.
//   The result sits in an output register; req is ready again as soon as the
//   result is loaded, so the next event is taken while rsp waits.
//   If rsp stalls while a new result is ready, the block holds that result
//   and takes no further event until the output register frees up.
//   Reset clears the per-channel row valid bits, both scan positions and all
//   handshake state; no clearing pass is needed, a row never written reads
//   as nothing pending and every velocity reads as zero.
module pending_key_event_table import pket_pkg::*; (
  input logic           clk,
  input logic           rst,
  pket_in_if.sink       req,
  pket_out_if.source    rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_GRP,
    S_PICK,
    S_RESP
  } state_t;

  state_t state;

  // registered command
  action_t            cmd_act;
  logic [CH_AW-1:0]   cmd_chan;
  logic [KEY_AW-1:0]  cmd_key;
  logic [VEL_W-1:0]   cmd_vel;
  logic               cmd_chan_ok;
  logic               cmd_key_ok;

  // persistent state in flops
  logic [CHANNEL_COUNT-1:0] row_vld;
  logic [POS_W-1:0]         on_pos;
  logic [POS_W-1:0]         off_pos;

  // scan pipeline
  logic [NGRP-1:0][GRP_W-1:0]  scan_word;
  logic [NGRP-1:0]             grp_any;
  logic [NGRP-1:0][GRP_AW-1:0] grp_off;
  row_t                        row_q;

  // result holding and output registers
  logic             res_found;
  logic [KEY_W-1:0] res_key;
  logic [VEL_W-1:0] res_vel;
  logic             out_valid;
  logic             out_found;
  logic [KEY_W-1:0] out_key;
  logic [VEL_W-1:0] out_vel;

  // memory ports
  logic             flag_we;
  row_t             flag_wdata;
  logic             flag_re;
  row_t             flag_rdata;
  logic             vel_we;
  logic [VEL_W-1:0] vel_wdata;
  logic [VEL_W-1:0] vel_rdata;
  logic [VEL_AW-1:0] vel_waddr;
  logic [VEL_AW-1:0] vel_raddr;

  logic req_xfer;
  logic out_free;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.found_key     = out_key;
  assign rsp.read_velocity = out_vel;

  // read addresses come straight from the accepted event
  assign flag_re   = req_xfer;
  assign vel_raddr = {CH_AW'(req.chan), KEY_AW'(req.key_number)};
  assign vel_waddr = {cmd_chan, cmd_key};

  pket_ram #(.WIDTH($bits(row_t)), .DEPTH(CHANNEL_COUNT)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (cmd_chan),
    .wdata (flag_wdata),
    .re    (flag_re),
    .raddr (CH_AW'(req.chan)),
    .rdata (flag_rdata)
  );

  pket_ram #(.WIDTH(VEL_W), .DEPTH(VEL_DEPTH)) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (vel_waddr),
    .wdata (vel_wdata),
    .re    (req_xfer),
    .raddr (vel_raddr),
    .rdata (vel_rdata)
  );

  // current row, unwritten rows read as nothing pending and nothing written
  logic cmd_ok;
  row_t row_cur;
  logic is_note;
  logic is_pop;
  logic pop_on;

  assign cmd_ok  = cmd_chan_ok && cmd_key_ok;
  assign row_cur = (cmd_chan_ok && row_vld[cmd_chan]) ? flag_rdata : '0;
  assign is_note = (cmd_act == ACT_NOTE_ON) || (cmd_act == ACT_NOTE_OFF);
  assign is_pop  = (cmd_act == ACT_POP_ON) || (cmd_act == ACT_POP_OFF);
  assign pop_on  = (cmd_act == ACT_POP_ON);

  // row update for note and clear actions
  logic [VEL_W-1:0] note_vel;
  row_t             row_edit;

  assign note_vel = (cmd_act == ACT_NOTE_ON) ? cmd_vel : '0;

  always_comb begin
    row_edit = row_cur;
    if (is_note) begin
      row_edit.pend_on[cmd_key]  = (note_vel != '0);
      row_edit.pend_off[cmd_key] = (note_vel == '0);
      row_edit.written[cmd_key]  = 1'b1;
    end else begin
      row_edit.pend_on[cmd_key]  = 1'b0;
      row_edit.pend_off[cmd_key] = 1'b0;
    end
  end

  // candidate keys at or above the scan position
  logic [POS_W-1:0]           pos_cur;
  logic                       pos_ok;
  logic [KEY_COUNT-1:0]       cand;
  logic [NGRP-1:0][GRP_W-1:0] scan_word_next;

  assign pos_cur = pop_on ? on_pos : off_pos;
  assign pos_ok  = (pos_cur < KEY_COUNT) && cmd_chan_ok;
  assign cand    = pop_on ? row_cur.pend_on : row_cur.pend_off;

  always_comb begin
    scan_word_next = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      scan_word_next[i / GRP_W][i % GRP_W] = cand[i] && pos_ok && (i >= int'(pos_cur));
    end
  end

  // lowest set bit inside each group
  logic [NGRP-1:0]             grp_any_next;
  logic [NGRP-1:0][GRP_AW-1:0] grp_off_next;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_next[g] = |scan_word[g];
      grp_off_next[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (scan_word[g][b]) begin
          grp_off_next[g] = GRP_AW'(b);
        end
      end
    end
  end

  // first group with a candidate
  logic               pick_hit;
  logic [NGRP_AW-1:0] pick_grp;
  logic [POS_W-1:0]   pick_pos;
  logic [KEY_AW-1:0]  pick_key;
  row_t               row_pop;

  always_comb begin
    pick_hit = 1'b0;
    pick_grp = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_hit = 1'b1;
        pick_grp = NGRP_AW'(g);
      end
    end
  end

  assign pick_pos = POS_W'({pick_grp, grp_off[pick_grp]});
  assign pick_key = KEY_AW'(pick_pos);

  always_comb begin
    row_pop = row_q;
    row_pop.pend_on[pick_key]  = 1'b0;
    row_pop.pend_off[pick_key] = 1'b0;
  end

  // memory writes
  always_comb begin
    flag_we    = 1'b0;
    flag_wdata = row_edit;
    vel_we     = 1'b0;
    vel_wdata  = note_vel;
    if (state == S_DATA && cmd_ok && (is_note || cmd_act == ACT_CLEAR)) begin
      flag_we = 1'b1;
      vel_we  = is_note;
    end else if (state == S_PICK && pick_hit) begin
      flag_we    = 1'b1;
      flag_wdata = row_pop;
    end
  end

  // sequencer, scan positions and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_vld   <= '0;
      on_pos    <= '0;
      off_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register loads a new result or drains on a transfer
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (flag_we) begin
        row_vld[cmd_chan] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          if (cmd_act == ACT_READ) begin
            res_found <= 1'b1;
            res_key   <= '0;
            res_vel   <= (cmd_ok && row_cur.written[cmd_key]) ? vel_rdata : '0;
            state     <= S_RESP;
          end else if (is_pop) begin
            state <= S_GRP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_GRP: begin
          state <= S_PICK;
        end
        S_PICK: begin
          res_found <= pick_hit;
          res_key   <= pick_hit ? KEY_W'(pick_pos) : '0;
          res_vel   <= '0;
          if (pop_on) begin
            on_pos <= pick_hit ? pick_pos : '0;
          end else begin
            off_pos <= pick_hit ? pick_pos : '0;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers without reset
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_act     <= req.action;
      cmd_chan    <= CH_AW'(req.chan);
      cmd_key     <= KEY_AW'(req.key_number);
      cmd_vel     <= req.new_velocity;
      cmd_chan_ok <= (req.chan < CHANNEL_COUNT);
      cmd_key_ok  <= (req.key_number < KEY_COUNT);
    end
    if (state == S_DATA) begin
      scan_word <= scan_word_next;
      row_q     <= row_cur;
    end
    if (state == S_GRP) begin
      grp_any <= grp_any_next;
      grp_off <= grp_off_next;
    end
    if (state == S_RESP && out_free) begin
      out_found <= res_found;
      out_key   <= res_key;
      out_vel   <= res_vel;
    end
  end

  // checks
  a_accept_to_data: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == S_DATA)
    else $error("accepted event did not move to row read");

  a_pick_is_candidate: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_hit) |-> scan_word[pick_grp][grp_off[pick_grp]])
    else $error("picked key is not a pending candidate");

  a_hit_needs_channel: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_hit) |-> cmd_chan_ok && pick_pos < KEY_COUNT)
    else $error("pop hit outside the table");

  a_key_only_when_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.found || rsp.found_key == '0)
    else $error("key returned without a hit");

endmodule
